// ----- rtl/capture_ratio_period_synth_unit_macros.svh -----
// ----------------------------------------------------------------------------
// capture ratio period synth unit - assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef CAPTURE_RATIO_PERIOD_SYNTH_UNIT_MACROS_SVH
`define CAPTURE_RATIO_PERIOD_SYNTH_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define CRPS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CRPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/crps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crps_pkg
// shared widths, codes and types of the capture ratio period synth unit
// ----------------------------------------------------------------------------
package crps_pkg;

  localparam int CFG_W      = 16;  // multiplier / divider register width
  localparam int FRAC_W     = 17;  // remainder, below 2*multiplier
  localparam int PERIOD_W   = 32;  // half period field
  localparam int CAP_FIELD_W = 32; // capture_time port
  localparam int CMP_FIELD_W = 16; // compare_value / out_timer_now ports
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_W-1:0]    MULT_RESET = 16'd12503;
  localparam logic [CFG_W-1:0]    DIVR_RESET = 16'd4096;
  localparam logic [PERIOD_W-1:0] PERIOD_SAT = 32'hffff_ffff;

  localparam logic [CFG_IDX_W-1:0] REG_MULTIPLIER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DIVIDER    = 1'b1;

  localparam logic REQ_EDGE  = 1'b0;
  localparam logic REQ_MATCH = 1'b1;

  // result handed from the serial divider to the control
  typedef struct packed {
    logic [PERIOD_W-1:0] half_period;
    logic [FRAC_W-1:0]   remainder;
  } div_res_t;

endpackage

// ----- rtl/crps_edge_cnt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crps_edge_cnt
// counts input edges and toggles the divided level every divider-th edge
// ----------------------------------------------------------------------------
module crps_edge_cnt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [crps_pkg::CFG_W-1:0] divider_i,
  output logic                       level_o
);
  import crps_pkg::*;

  logic [CFG_W-1:0] count_q, count_d;
  logic             level_q, level_d;
  logic [CFG_W:0]   cnt_inc;
  logic             wrap;

  assign cnt_inc = {1'b0, count_q} + (CFG_W+1)'(1);
  // wraps on reaching divider or on passing the counter range
  assign wrap    = (cnt_inc >= {1'b0, divider_i}) || cnt_inc[CFG_W];

  always_comb begin
    count_d = count_q;
    level_d = level_q;
    if (step_i) begin
      if (wrap) begin
        count_d = '0;
        level_d = ~level_q;
      end else begin
        count_d = cnt_inc[CFG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      level_q <= 1'b0;
    end else begin
      count_q <= count_d;
      level_q <= level_d;
    end
  end

  assign level_o = level_q;

endmodule

// ----- rtl/crps_serial_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crps_serial_div
// bit-serial multiply then restoring divide:
// (interval*divider + frac) / den, one bit per cycle
// ----------------------------------------------------------------------------
module crps_serial_div #(
  parameter int IV_W = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [IV_W-1:0]             interval_i,
  input  logic [crps_pkg::CFG_W-1:0]  divider_i,
  input  logic [crps_pkg::FRAC_W-1:0] den_i,
  input  logic [crps_pkg::FRAC_W-1:0] frac_i,
  output logic                        done_o,
  output crps_pkg::div_res_t          res_o
);
  import crps_pkg::*;

  localparam int SUM_W = IV_W + CFG_W;
  localparam int CNT_W = $clog2(SUM_W);

  localparam logic [1:0] U_IDLE = 2'd0;
  localparam logic [1:0] U_MUL  = 2'd1;
  localparam logic [1:0] U_DIV  = 2'd2;

  logic [1:0]        ustate_q, ustate_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [SUM_W-1:0]  acc_q, acc_d;
  logic [FRAC_W-1:0] rem_q, rem_d;
  logic [IV_W-1:0]   iv_q, iv_d;
  logic [CFG_W-1:0]  dsr_q, dsr_d;

  logic [SUM_W-1:0]  pp;
  logic [SUM_W-1:0]  fr_add;
  logic [FRAC_W:0]   shifted;
  logic [FRAC_W:0]   diff;
  logic              ge;
  logic              sat;

  // multiply digit: one divider bit, msb first
  assign pp     = dsr_q[CFG_W-1] ? SUM_W'(iv_q) : '0;
  assign fr_add = (cnt_q == '0) ? SUM_W'(frac_i) : '0;

  // divide digit: one quotient bit into the accumulator lsb
  assign shifted = {rem_q, acc_q[SUM_W-1]};
  assign ge      = shifted >= {1'b0, den_i};
  assign diff    = shifted - {1'b0, den_i};

  always_comb begin
    ustate_d = ustate_q;
    cnt_d    = cnt_q;
    done_d   = 1'b0;
    acc_d    = acc_q;
    rem_d    = rem_q;
    iv_d     = iv_q;
    dsr_d    = dsr_q;
    unique case (ustate_q)
      U_IDLE: begin
        if (start_i) begin
          ustate_d = U_MUL;
          cnt_d    = CNT_W'(CFG_W - 1);
          acc_d    = '0;
          iv_d     = interval_i;
          dsr_d    = divider_i;
        end
      end
      U_MUL: begin
        acc_d = {acc_q[SUM_W-2:0], 1'b0} + pp + fr_add;
        dsr_d = {dsr_q[CFG_W-2:0], 1'b0};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          ustate_d = U_DIV;
          cnt_d    = CNT_W'(SUM_W - 1);
          rem_d    = '0;
        end
      end
      U_DIV: begin
        acc_d = {acc_q[SUM_W-2:0], ge};
        rem_d = ge ? diff[FRAC_W-1:0] : shifted[FRAC_W-1:0];
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          ustate_d = U_IDLE;
          done_d   = 1'b1;
        end
      end
      default: ustate_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ustate_q <= U_IDLE;
      cnt_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      ustate_q <= ustate_d;
      cnt_q    <= cnt_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    iv_q  <= iv_d;
    dsr_q <= dsr_d;
  end

  // quotient sits in acc, remainder in rem, held until the next start
  assign sat = (den_i == '0) || (acc_q > SUM_W'(PERIOD_SAT));

  assign res_o.half_period = sat ? PERIOD_SAT : acc_q[PERIOD_W-1:0];
  assign res_o.remainder   = sat ? '0 : rem_q;
  assign done_o            = done_q;

endmodule

// ----- rtl/capture_ratio_period_synth_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capture_ratio_period_synth_unit
// input capture frequency multiplier: half period = interval*divider/(2*mult)
// with exact remainder carry, compare value stepping and edge divided output
// ----------------------------------------------------------------------------
//
// channel   dir  handshake                  payload
// in        in   in_valid_i / in_ready_o     req_type, capture_time, out_timer_now
// out       out  out_valid_o / out_ready_i   half_period, compare_value,
//                                            compare_load, divided_level,
//                                            zero_interval_error, running
// cfg       in   cfg_we_i (no wait)          cfg_idx_i, cfg_wdata_i
//
// edges that compute a period go through the bit-serial multiply, one digit
// per divider bit, and restoring divide unit, then the done state; other
// items go from accept straight to the done state and the result
// one item is in work at a time; a new item is taken while a result waits
// a waiting result stalls only the commit of the next item
// reset clears the control state, not the held item or divider datapath, and restores the register defaults
// ----------------------------------------------------------------------------
`include "capture_ratio_period_synth_unit_macros.svh"

module capture_ratio_period_synth_unit #(
  parameter int CAPTURE_BITS = 32,
  parameter int COMPARE_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [crps_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [crps_pkg::CFG_W-1:0]        cfg_wdata_i,
  // input items
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              req_type_i,
  input  logic [crps_pkg::CAP_FIELD_W-1:0]  capture_time_i,
  input  logic [crps_pkg::CMP_FIELD_W-1:0]  out_timer_now_i,
  // result items
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [crps_pkg::PERIOD_W-1:0]     half_period_o,
  output logic [crps_pkg::CMP_FIELD_W-1:0]  compare_value_o,
  output logic                              compare_load_o,
  output logic                              divided_level_o,
  output logic                              zero_interval_error_o,
  output logic                              running_o
);
  import crps_pkg::*;

  // control states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  // capture history codes
  localparam logic [1:0] SEEN_NONE = 2'd0;
  localparam logic [1:0] SEEN_ONE  = 2'd1;
  localparam logic [1:0] SEEN_RUN  = 2'd2;

  logic [1:0]              state_q, state_d;

  // configuration registers
  logic [CFG_W-1:0]        mult_q, divr_q;

  // block state
  logic [CAPTURE_BITS-1:0] last_q, last_d;
  logic [1:0]              seen_q, seen_d;
  logic [FRAC_W-1:0]       frac_q, frac_d;
  logic [PERIOD_W-1:0]     period_q, period_d;
  logic [COMPARE_BITS-1:0] cmp_q, cmp_d;
  logic                    started_q, started_d;

  // held item and its interval
  logic                    req_q;
  logic [CAPTURE_BITS-1:0] cap_q;
  logic [CMP_FIELD_W-1:0]  timer_q;
  logic [CAPTURE_BITS-1:0] iv_q;

  // result flags
  logic                    out_valid_q, out_valid_d;
  logic                    load_q, load_d;
  logic                    err_q, err_d;

  logic                    accept;
  logic                    commit;
  logic                    out_free;
  logic [CAPTURE_BITS-1:0] iv_new;
  logic                    div_start;
  logic                    div_done;
  div_res_t                div_res;
  logic                    edge_step;
  logic [PERIOD_W-1:0]     iv_ext;
  logic [FRAC_W-1:0]       den;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign commit     = (state_q == S_DONE) && out_free;

  // interval modulo 2^CAPTURE_BITS against the previous edge
  assign iv_new    = capture_time_i[CAPTURE_BITS-1:0] - last_q;
  assign div_start = accept && (req_type_i == REQ_EDGE) && (seen_q != SEEN_NONE)
                     && (iv_new != '0);
  assign den       = {mult_q, 1'b0};
  assign edge_step = commit && (req_q == REQ_EDGE);
  assign iv_ext    = PERIOD_W'(iv_q);

  crps_serial_div #(
    .IV_W (CAPTURE_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .interval_i (iv_new),
    .divider_i  (divr_q),
    .den_i      (den),
    .frac_i     (frac_q),
    .done_o     (div_done),
    .res_o      (div_res)
  );

  crps_edge_cnt u_edge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (edge_step),
    .divider_i (divr_q),
    .level_o   (divided_level_o)
  );

  // sequencing
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = div_start ? S_DIV : S_DONE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state update at commit, once the result slot is free
  always_comb begin
    last_d      = last_q;
    seen_d      = seen_q;
    frac_d      = frac_q;
    period_d    = period_q;
    cmp_d       = cmp_q;
    started_d   = started_q;
    load_d      = load_q;
    err_d       = err_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
      load_d      = 1'b0;
      err_d       = 1'b0;
      if (req_q == REQ_EDGE) begin
        last_d = cap_q;
        if (seen_q == SEEN_NONE) begin
          // first edge only records its timestamp
          seen_d = SEEN_ONE;
        end else if (iv_q == '0) begin
          err_d = 1'b1;
        end else begin
          period_d = div_res.half_period;
          frac_d   = div_res.remainder;
          if (seen_q == SEEN_ONE) begin
            // starting edge: first compare one interval after the timer
            cmp_d     = COMPARE_BITS'(timer_q) + iv_ext[COMPARE_BITS-1:0];
            started_d = 1'b1;
            seen_d    = SEEN_RUN;
            load_d    = 1'b1;
          end
        end
      end else if (started_q) begin
        // compare match: step by the half period, wrapping
        cmp_d  = cmp_q + period_q[COMPARE_BITS-1:0];
        load_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mult_q      <= MULT_RESET;
      divr_q      <= DIVR_RESET;
      last_q      <= '0;
      seen_q      <= SEEN_NONE;
      frac_q      <= '0;
      period_q    <= '0;
      cmp_q       <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
      load_q      <= 1'b0;
      err_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      seen_q      <= seen_d;
      frac_q      <= frac_d;
      period_q    <= period_d;
      cmp_q       <= cmp_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
      load_q      <= load_d;
      err_q       <= err_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_MULTIPLIER: mult_q <= cfg_wdata_i;
          REG_DIVIDER:    divr_q <= cfg_wdata_i;
          default:        ;
        endcase
      end
    end
  end

  // item capture, payload only
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q   <= req_type_i;
      cap_q   <= capture_time_i[CAPTURE_BITS-1:0];
      timer_q <= out_timer_now_i;
      iv_q    <= iv_new;
    end
  end

  // state registers change only at commit, so they are the result fields
  assign out_valid_o           = out_valid_q;
  assign half_period_o         = period_q;
  assign compare_value_o       = cmp_q[CMP_FIELD_W-1:0];
  assign compare_load_o        = load_q;
  assign zero_interval_error_o = err_q;
  assign running_o             = started_q;

  // an accepted item always leaves idle
  `CRPS_ASSERT_NEXT(a_accept_busy, accept, state_q != S_IDLE, "accept did not leave idle")
  // the divider only finishes while the control waits for it
  `CRPS_ASSERT_SAME(a_done_in_div, div_done, state_q == S_DIV, "divider done outside wait")
  // a compare load needs a started output
  `CRPS_ASSERT_SAME(a_load_running, out_valid_o && compare_load_o, running_o,
                    "compare load before start")
  // a zero interval never loads a compare value
  `CRPS_ASSERT_SAME(a_err_no_load, out_valid_o && zero_interval_error_o, !compare_load_o,
                    "compare load with zero interval")

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - capture ratio period synth unit testbench
// drives edge and compare match items through the valid/ready input, keeps
// its own copy of the period ratio state, and checks every result item field
// by field under several register settings and idling mixes
// ----------------------------------------------------------------------------
module tb;
  import crps_pkg::*;

  localparam int QUIET_LIMIT     = 20000; // cycles with no handshake at all
  localparam int SETTLE_CYCLES   = 8;     // idle cycles before a register write
  localparam int TAIL_CYCLES     = 100;   // longer than one divide of the block
  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 140;

  // how far the capture history has come
  typedef enum logic [1:0] {
    EDGES_NONE,
    EDGES_ONE,
    EDGES_RUNNING
  } edge_history_e;

  typedef struct packed {
    logic [PERIOD_W-1:0]    half_period;
    logic [CMP_FIELD_W-1:0] compare_value;
    logic                   compare_load;
    logic                   divided_level;
    logic                   zero_interval_error;
    logic                   running;
  } synth_result_t;

  // tracks the ratio state and holds the results still owed by the block
  class ratio_tracker;
    logic [CFG_W-1:0]       mult;
    logic [CFG_W-1:0]       divr;
    logic [31:0]            last_cap;
    edge_history_e          history;
    logic [FRAC_W-1:0]      frac;
    logic [PERIOD_W-1:0]    period;
    logic [CMP_FIELD_W-1:0] cmp;
    logic [15:0]            edge_cnt;
    logic                   div_bit;
    logic                   started;
    synth_result_t          pending_results[$];
    int unsigned            errors;

    function new();
      mult     = MULT_RESET;
      divr     = DIVR_RESET;
      last_cap = '0;
      history  = EDGES_NONE;
      frac     = '0;
      period   = '0;
      cmp      = '0;
      edge_cnt = '0;
      div_bit  = 1'b0;
      started  = 1'b0;
      errors   = 0;
    endfunction

    function void set_ratio(logic [CFG_W-1:0] m, logic [CFG_W-1:0] d);
      mult = m;
      divr = d;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // exact division with the remainder carried to the next edge
    function void update_half_period(logic [31:0] ivl);
      logic [63:0] den;
      logic [63:0] sum;
      logic [63:0] quo;
      logic [63:0] rem;
      den = 64'(mult) << 1;
      sum = 64'(ivl) * 64'(divr) + 64'(frac);
      if (den == 64'd0) begin
        period = PERIOD_SAT;
        frac   = '0;
      end else begin
        quo = sum / den;
        rem = sum % den;
        if (quo > 64'(PERIOD_SAT)) begin
          period = PERIOD_SAT;
          frac   = '0;
        end else begin
          period = quo[PERIOD_W-1:0];
          frac   = rem[FRAC_W-1:0];
        end
      end
    endfunction

    function void accept_item(logic req, logic [31:0] cap, logic [15:0] tmr);
      synth_result_t res;
      logic [16:0]   cnt;
      logic [31:0]   ivl;
      logic          load;
      logic          err;
      load = 1'b0;
      err  = 1'b0;
      if (req == REQ_EDGE) begin
        // edge divider, compare matches do not count
        cnt = {1'b0, edge_cnt} + 17'd1;
        if (cnt >= {1'b0, divr} || cnt > 17'hffff) begin
          div_bit  = ~div_bit;
          edge_cnt = '0;
        end else begin
          edge_cnt = cnt[15:0];
        end
        if (history == EDGES_NONE) begin
          last_cap = cap;
          history  = EDGES_ONE;
        end else begin
          ivl      = cap - last_cap;
          last_cap = cap;
          if (ivl == 32'd0) begin
            err = 1'b1;
          end else begin
            update_half_period(ivl);
            if (history == EDGES_ONE) begin
              cmp     = tmr + ivl[15:0];
              started = 1'b1;
              history = EDGES_RUNNING;
              load    = 1'b1;
            end
          end
        end
      end else if (started) begin
        cmp  = cmp + period[15:0];
        load = 1'b1;
      end
      res.half_period         = period;
      res.compare_value       = cmp;
      res.compare_load        = load;
      res.divided_level       = div_bit;
      res.zero_interval_error = err;
      res.running             = started;
      pending_results.push_back(res);
    endfunction

    function void report(string field, logic [31:0] exp_val, logic [31:0] act_val);
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, exp_val, act_val);
    endfunction

    function void check_result(synth_result_t act);
      synth_result_t exp_res;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual %h", $time, act);
        return;
      end
      exp_res = pending_results.pop_front();
      if (exp_res.half_period !== act.half_period)
        report("half_period", exp_res.half_period, act.half_period);
      if (exp_res.compare_value !== act.compare_value)
        report("compare_value", 32'(exp_res.compare_value), 32'(act.compare_value));
      if (exp_res.compare_load !== act.compare_load)
        report("compare_load", 32'(exp_res.compare_load), 32'(act.compare_load));
      if (exp_res.divided_level !== act.divided_level)
        report("divided_level", 32'(exp_res.divided_level), 32'(act.divided_level));
      if (exp_res.zero_interval_error !== act.zero_interval_error)
        report("zero_interval_error", 32'(exp_res.zero_interval_error),
               32'(act.zero_interval_error));
      if (exp_res.running !== act.running)
        report("running", 32'(exp_res.running), 32'(act.running));
    endfunction
  endclass

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #10 clk_i = ~clk_i;

  // block inputs, all known from time zero
  logic                   cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i       = REG_MULTIPLIER;
  logic [CFG_W-1:0]       cfg_wdata_i     = '0;
  logic                   in_valid_i      = 1'b0;
  logic                   req_type_i      = REQ_EDGE;
  logic [CAP_FIELD_W-1:0] capture_time_i  = '0;
  logic [CMP_FIELD_W-1:0] out_timer_now_i = '0;
  logic                   out_ready_i     = 1'b0;

  logic                   in_ready_o;
  logic                   out_valid_o;
  logic [PERIOD_W-1:0]    half_period_o;
  logic [CMP_FIELD_W-1:0] compare_value_o;
  logic                   compare_load_o;
  logic                   divided_level_o;
  logic                   zero_interval_error_o;
  logic                   running_o;

  capture_ratio_period_synth_unit DUT (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .req_type_i            (req_type_i),
    .capture_time_i        (capture_time_i),
    .out_timer_now_i       (out_timer_now_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .half_period_o         (half_period_o),
    .compare_value_o       (compare_value_o),
    .compare_load_o        (compare_load_o),
    .divided_level_o       (divided_level_o),
    .zero_interval_error_o (zero_interval_error_o),
    .running_o             (running_o)
  );

  ratio_tracker tracker;

  // idling mix, percent of cycles
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;

  // running capture timestamp of the edge source
  logic [31:0] cap_now = '0;

  // receiver: ready redrawn every cycle from the current stall rate
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // result monitor, sampled values are the ones before the edge
  always @(posedge clk_i) begin
    synth_result_t act;
    if (rst_ni && out_valid_o && out_ready_i) begin
      act.half_period         = half_period_o;
      act.compare_value       = compare_value_o;
      act.compare_load        = compare_load_o;
      act.divided_level       = divided_level_o;
      act.zero_interval_error = zero_interval_error_o;
      act.running             = running_o;
      tracker.check_result(act);
    end
  end

  // watchdog on cycles where neither channel moves an item
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("%0t: timeout, no item moved for %0d cycles", $time, QUIET_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // 0 none, 1 sender gaps, 2 receiver stalls, 3 both at a lighter rate
  task automatic set_idling(int unsigned mode);
    case (mode)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 88; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 88; end
      default: begin gap_pct = 37; stall_pct = 37; end
    endcase
  endtask

  // one item through the input handshake; valid stays up afterwards so the
  // next item can follow back to back, gaps and pauses lower it
  task automatic send_item(logic req, logic [31:0] cap, logic [15:0] tmr);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    req_type_i      <= req;
    capture_time_i  <= cap;
    out_timer_now_i <= tmr;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.accept_item(req, cap, tmr);
  endtask

  task automatic send_edge(logic [31:0] ivl);
    cap_now = cap_now + ivl;
    send_item(REQ_EDGE, cap_now, 16'($urandom()));
  endtask

  // compare matches carry random timestamps that the block must ignore
  task automatic send_match();
    send_item(REQ_MATCH, $urandom(), 16'($urandom()));
  endtask

  // stop sending and let every owed result come out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // both registers written back to back while the block is idle
  task automatic set_ratio(logic [CFG_W-1:0] m, logic [CFG_W-1:0] d);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_MULTIPLIER;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_idx_i   <= REG_DIVIDER;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tracker.set_ratio(m, d);
  endtask

  task automatic send_random_item();
    int unsigned pick;
    logic [31:0] ivl;
    pick = $urandom_range(99);
    if (pick < 45) begin
      send_match();
    end else begin
      pick = $urandom_range(99);
      if (pick < 5)       ivl = 32'd0;              // repeated timestamp
      else if (pick < 15) ivl = $urandom();         // any gap, wraps too
      else if (pick < 25) ivl = $urandom_range(1, 16);
      else                ivl = $urandom_range(17, 1000000);
      send_edge(ivl);
    end
  endtask

  initial begin
    tracker = new();
    set_idling(0);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset ratio: compare match before start is ignored
    send_item(REQ_MATCH, 32'hffff_ffff, 16'hffff);
    // first edge only records, the repeat gives a zero interval and no start
    cap_now = 32'h1000_0000;
    send_item(REQ_EDGE, cap_now, 16'h0000);
    send_item(REQ_EDGE, cap_now, 16'hffff);
    // starting edge, compare value wraps past the top of the timer
    cap_now = cap_now + 32'd50021;
    send_item(REQ_EDGE, cap_now, 16'hffff);
    repeat (3) send_match();
    // timestamp wraps back through zero
    cap_now = 32'h0000_0010;
    send_item(REQ_EDGE, cap_now, 16'h1234);
    send_edge(32'd0);
    send_edge(32'hffff_ffff);
    send_match();

    // smallest multiplier and largest divider: quotient saturates
    set_ratio(16'd1, 16'hffff);
    send_edge(32'hffff_ffff);
    send_match();
    send_edge(32'd1);
    send_edge(32'd3);
    send_match();

    // zero multiplier saturates, zero divider gives a zero period and
    // toggles the divided output on every edge
    set_ratio(16'd0, 16'd7);
    send_edge(32'd5);
    send_match();
    set_ratio(16'd3, 16'd0);
    send_edge(32'd100);
    send_edge(32'd1);
    send_match();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: set_ratio(MULT_RESET, DIVR_RESET);
        1: set_ratio(16'd1, 16'hffff);
        2: set_ratio(16'hffff, 16'd1);
        3: set_ratio(16'd0, 16'd0);
        4: set_ratio(16'hffff, 16'hffff);
        5: set_ratio(16'd1, 16'd1);
        6: set_ratio(16'd0, 16'd2);
        7: set_ratio(16'd3, 16'd0);
        default: set_ratio(16'($urandom()), 16'($urandom_range(1, 12)));
      endcase
      set_idling(p % 4);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // halfway through, hold off until the block has caught up
        if (n == ITEMS_PER_PHASE / 2) drain_results();
        send_random_item();
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tracker.pending() != 0) begin
      tracker.errors += tracker.pending();
      $display("%0t: %0d results never arrived", $time, tracker.pending());
    end
    if (tracker.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
